@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/dmvm_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Matrix-vector multiply package
// Beat types, command bundle and codes shared by the controller and datapath.
// ---------------------------------------------------------------------------
package dmvm_pkg;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_MATRIX = 1'b1;

	localparam logic CFG_COLUMN_COUNT = 1'b0;
	localparam logic CFG_ROW_COUNT    = 1'b1;

	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic               kind;
		logic [7:0]         column_index;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] row_sum;
		logic [15:0]        row_index;
		logic               last_row;
	} out_item_t;

	typedef struct packed {
		logic        load_we;
		logic        rd_en;
		logic        mul_en;
		logic        acc_en;
		logic        round_en;
		logic [15:0] row_index;
		logic        last_row;
	} dp_cmd_t;

endpackage

@@ rtl/dense_matrix_vector_multiply_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dense matrix-vector multiply unit
// Q16.16 matrix-vector product: vector loads into a store, matrix entries
// streamed row-major, one saturated Q16.16 sum per completed row.
// ---------------------------------------------------------------------------
//  Channel   Handshake                    Beat
//  item      start / busy                 kind, column_index, value
//  result    result_strobe (one cycle)    row_sum, row_index, last_row
//  config    cfg_valid / cfg_ready        cfg_index, cfg_data
//
//  A load beat leaves busy low.
//  A matrix beat steps through store read, multiply and accumulate, and a
//  rounding step as well when it closes a row; start is ignored while busy.
//  The row result appears in the cycle after the rounding step, for one cycle.
//  Reset clears positions and the accumulator; the vector store is undefined
//  until loaded. The result side cannot stall.
// ---------------------------------------------------------------------------
module dense_matrix_vector_multiply_unit #(
	parameter int MAX_COLUMNS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  dmvm_pkg::in_item_t              item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [dmvm_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            result_strobe,
	output dmvm_pkg::out_item_t             result
);
	import dmvm_pkg::*;

	localparam int AW = $clog2(MAX_COLUMNS);

	dp_cmd_t       cmd;
	logic [AW-1:0] addr;

	dmvm_ctrl #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.addr      (addr)
	);

	dmvm_datapath #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.addr          (addr),
		.value         (item.value),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule

@@ rtl/dmvm_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Matrix-vector multiply datapath
// Vector store, 32x32 multiplier, saturating Q32.32 accumulator and Q16.16
// rounding output stage.
// ---------------------------------------------------------------------------
module dmvm_datapath #(
	parameter int MAX_COLUMNS = 256,
	localparam int AW = $clog2(MAX_COLUMNS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dmvm_pkg::dp_cmd_t   cmd,
	input  logic [AW-1:0]       addr,
	input  logic signed [31:0]  value,
	output logic                result_strobe,
	output dmvm_pkg::out_item_t result
);
	import dmvm_pkg::*;

	localparam logic signed [48:0] Q_MAX = 49'sd2147483647;
	localparam logic signed [48:0] Q_MIN = -49'sd2147483648;

	logic signed [31:0] vec_mem [MAX_COLUMNS];
	logic signed [31:0] vec_s1;
	logic signed [31:0] value_s1;
	logic signed [63:0] prod_s2;
	logic signed [63:0] acc_q;
	logic signed [64:0] sum_wide;
	logic signed [63:0] sum_sat;
	logic signed [48:0] rnd;
	logic signed [31:0] rnd_sat;
	out_item_t          result_q;
	logic               strobe_q;

	// vector store: one port, read data registered
	always_ff @(posedge clk) begin
		if (cmd.load_we) begin
			vec_mem[addr] <= value;
		end
		if (cmd.rd_en) begin
			vec_s1   <= vec_mem[addr];
			value_s1 <= value;
		end
		if (cmd.mul_en) begin
			prod_s2 <= value_s1 * vec_s1;
		end
	end

	always_comb begin
		sum_wide = {acc_q[63], acc_q} + {prod_s2[63], prod_s2};
		// clamp when the carry out disagrees with the sign
		if (sum_wide[64] != sum_wide[63]) begin
			sum_sat = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			sum_sat = sum_wide[63:0];
		end
		// floor to Q16.16, then add the half bit: ties go up
		rnd = {acc_q[63], acc_q[63:16]} + 49'($unsigned(acc_q[15]));
		if (rnd > Q_MAX) begin
			rnd_sat = Q_MAX[31:0];
		end else if (rnd < Q_MIN) begin
			rnd_sat = Q_MIN[31:0];
		end else begin
			rnd_sat = rnd[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.round_en;
			if (cmd.round_en) begin
				acc_q <= '0;
			end else if (cmd.acc_en) begin
				acc_q <= sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.round_en) begin
			result_q.row_sum   <= rnd_sat;
			result_q.row_index <= cmd.row_index;
			result_q.last_row  <= cmd.last_row;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule

@@ rtl/dmvm_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Matrix-vector multiply controller
// Configuration registers, column and row positions, and the sequencer that
// steps the datapath through read, multiply, accumulate and round.
// ---------------------------------------------------------------------------
module dmvm_ctrl #(
	parameter int MAX_COLUMNS = 256,
	localparam int AW = $clog2(MAX_COLUMNS)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  dmvm_pkg::in_item_t             item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [dmvm_pkg::CFG_DATA_W-1:0] cfg_data,
	output dmvm_pkg::dp_cmd_t              cmd,
	output logic [AW-1:0]                  addr
);
	import dmvm_pkg::*;

	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int EW    = (CNT_W > 9) ? CNT_W : 9;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_ROUND
	} state_t;

	state_t        state_q;
	logic [8:0]    col_cnt_q;
	logic [15:0]   row_cnt_q;
	logic [8:0]    col_pos_q;
	logic [15:0]   row_pos_q;
	logic [15:0]   row_idx_q;
	logic          last_q;
	logic          row_end_q;

	logic          accept;
	logic          acc_mat;
	logic          acc_load;
	logic          load_ok;
	logic [EW-1:0] cols_ext;
	logic [EW-1:0] cols_eff;
	logic [EW-1:0] pos_ext;
	logic [EW-1:0] col_sel;
	logic          row_end_d;
	logic [15:0]   rows_eff;
	logic          last_d;

	always_comb begin
		accept   = start && !busy;
		acc_mat  = accept && (item.kind == KIND_MATRIX);
		acc_load = accept && (item.kind == KIND_LOAD);
		load_ok  = 32'(item.column_index) < 32'(MAX_COLUMNS);

		cols_ext = EW'(col_cnt_q);
		if (cols_ext == '0) begin
			cols_eff = EW'(1);
		end else if (cols_ext > EW'(MAX_COLUMNS)) begin
			cols_eff = EW'(MAX_COLUMNS);
		end else begin
			cols_eff = cols_ext;
		end
		pos_ext   = EW'(col_pos_q);
		// position past a shortened row reads the last column
		col_sel   = (pos_ext >= cols_eff) ? cols_eff - EW'(1) : pos_ext;
		row_end_d = pos_ext >= cols_eff - EW'(1);

		rows_eff = (row_cnt_q == '0) ? 16'd1 : row_cnt_q;
		last_d   = row_pos_q >= rows_eff - 16'd1;

		addr = acc_mat ? AW'(col_sel) : AW'(item.column_index);

		cmd.load_we   = acc_load && load_ok;
		cmd.rd_en     = acc_mat;
		cmd.mul_en    = state_q == S_MUL;
		cmd.acc_en    = state_q == S_ACC;
		cmd.round_en  = state_q == S_ROUND;
		cmd.row_index = row_idx_q;
		cmd.last_row  = last_q;
	end

	assign busy      = state_q != S_IDLE;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			col_cnt_q <= 9'd256;
			row_cnt_q <= 16'd1;
			col_pos_q <= '0;
			row_pos_q <= '0;
			row_idx_q <= '0;
			last_q    <= 1'b0;
			row_end_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_COLUMN_COUNT: col_cnt_q <= cfg_data[8:0];
					CFG_ROW_COUNT:    row_cnt_q <= cfg_data[15:0];
					default:          ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_mat) begin
						state_q   <= S_MUL;
						row_end_q <= row_end_d;
						row_idx_q <= row_pos_q;
						last_q    <= last_d;
						if (row_end_d) begin
							col_pos_q <= '0;
							row_pos_q <= last_d ? 16'd0 : row_pos_q + 16'd1;
						end else begin
							col_pos_q <= col_pos_q + 9'd1;
						end
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					state_q <= row_end_q ? S_ROUND : S_IDLE;
				end
				S_ROUND: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEXT(a_matrix_beat_busy, clk, arst_n, acc_mat, busy, "matrix beat did not start work")
	`ASSERT_IMPLY(a_round_at_row_end, clk, arst_n, cmd.round_en, row_end_q, "round without row end")
	`ASSERT_NEXT(a_row_wrap, clk, arst_n, acc_mat && row_end_d && last_d, row_pos_q == '0, "row position did not wrap")
	`ASSERT_IMPLY(a_load_idle, clk, arst_n, cmd.load_we, !busy, "store written while busy")

endmodule
